### rtl/crc32c_string_bucket_hash_core_macros.svh
// assertion macros for the checker file cbh_checker
// depends on a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef CRC32C_STRING_BUCKET_HASH_CORE_MACROS_SVH
`define CRC32C_STRING_BUCKET_HASH_CORE_MACROS_SVH

// same-cycle implication
`define CBH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cbh assertion failed");

// next-cycle implication
`define CBH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cbh assertion failed");

`endif

### rtl/cbh_pkg.sv
// shared widths, constants and types of the crc32c bucket hash block
// used by cbh_mod_unit and crc32c_string_bucket_hash_core
package cbh_pkg;

    localparam int CRC_W    = 32;
    localparam int BKT_W    = 31;
    localparam int BYTE_W   = 8;
    localparam int DIV_CNT_W = 5;

    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [BKT_W-1:0] BKT_RESET = 31'd1024;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 5'd31;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    // reflected crc-32c update over one byte, lsb first
    function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/crc32c_string_bucket_hash_core.sv
// top level of the crc32c key hash with bucket selection
// depends on cbh_pkg and cbh_mod_unit
//
// Key bytes are taken one per request and folded into a reflected CRC-32C
// register (start value all ones, no final inversion), one byte per cycle.
// A byte without last_byte is accepted back to back, one per cycle. A request
// that ends a key (last_byte, or empty_key, which wins and carries no byte)
// hands the raw CRC to a remainder unit that works one dividend bit per
// cycle, so the input stalls after it through the remainder steps, the state
// that sees the unit finish and the one that loads the output register, and
// while the output is still held by a stall on the far side. The output
// register holds crc_value and crc_value modulo bucket_count (0 when the
// count is 0). bucket_count resets to 1024 and may only be written while no
// key end is in flight.
module crc32c_string_bucket_hash_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [cbh_pkg::BKT_W-1:0]  i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [cbh_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_last_byte,
    input  logic                       i_empty_key,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [cbh_pkg::BKT_W-1:0]  o_bucket_index,
    output logic [cbh_pkg::CRC_W-1:0]  o_crc_value
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]                     r_state, n_state;
    logic [cbh_pkg::CRC_W-1:0]      r_crc, n_crc;
    logic [cbh_pkg::CRC_W-1:0]      r_key_crc, n_key_crc;
    logic [cbh_pkg::BKT_W-1:0]      r_bucket_count;
    logic                           r_out_valid, n_out_valid;
    logic [cbh_pkg::BKT_W-1:0]      r_out_index, n_out_index;
    logic [cbh_pkg::CRC_W-1:0]      r_out_crc, n_out_crc;
    logic [cbh_pkg::CRC_W-1:0]      folded;
    logic                           accept;
    logic                           div_start;
    logic                           out_free;
    logic                           load_out;
    cbh_pkg::t_div_status           div_status;
    logic [cbh_pkg::BKT_W-1:0]      div_rem;

    assign accept   = i_in_valid && !o_in_stall;
    assign folded   = cbh_pkg::fold_byte(r_crc, i_data_byte);
    assign out_free = !r_out_valid || !i_out_stall;

    cbh_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_key_crc),
        .i_divisor  (r_bucket_count),
        .o_status   (div_status),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state   = r_state;
        n_crc     = r_crc;
        n_key_crc = r_key_crc;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_empty_key || i_last_byte) begin
                        n_key_crc = i_empty_key ? r_crc : folded;
                        n_crc     = cbh_pkg::CRC_INIT;
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end else begin
                        n_crc = folded;
                    end
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_index = r_out_index;
        n_out_crc   = r_out_crc;
        if (load_out) begin
            n_out_valid = 1'b1;
            n_out_crc   = r_key_crc;
            // a zero bucket count gives index 0
            n_out_index = (r_bucket_count == '0) ? '0 : div_rem;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_crc          <= cbh_pkg::CRC_INIT;
            r_bucket_count <= cbh_pkg::BKT_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_bucket_count <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_crc   <= n_key_crc;
        r_out_index <= n_out_index;
        r_out_crc   <= n_out_crc;
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_bucket_index = r_out_index;
    assign o_crc_value    = r_out_crc;

endmodule

### rtl/cbh_mod_unit.sv
// restoring remainder unit, one dividend bit per cycle
// depends on cbh_pkg
module cbh_mod_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cbh_pkg::CRC_W-1:0]  i_dividend,
    input  logic [cbh_pkg::BKT_W-1:0]  i_divisor,
    output cbh_pkg::t_div_status       o_status,
    output logic [cbh_pkg::BKT_W-1:0]  o_rem
);

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [cbh_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [cbh_pkg::CRC_W-1:0]       r_quo, n_quo;
    logic [cbh_pkg::BKT_W-1:0]       r_rem, n_rem;
    logic [cbh_pkg::CRC_W-1:0]       partial;
    logic [cbh_pkg::CRC_W-1:0]       diff;
    logic                            ge;

    // shift next dividend bit into the partial remainder and try a subtract
    assign partial = {r_rem, r_quo[cbh_pkg::CRC_W-1]};
    assign diff    = partial - {1'b0, i_divisor};
    assign ge      = partial >= {1'b0, i_divisor};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = cbh_pkg::DIV_LAST_STEP;
            n_quo  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_quo = {r_quo[cbh_pkg::CRC_W-2:0], 1'b0};
            n_rem = ge ? diff[cbh_pkg::BKT_W-1:0] : partial[cbh_pkg::BKT_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_rem         = r_rem;

endmodule

### rtl/cbh_checker.sv
// port-level checks for crc32c_string_bucket_hash_core, bound to the top level
// depends on cbh_pkg and crc32c_string_bucket_hash_core_macros.svh
`include "crc32c_string_bucket_hash_core_macros.svh"

module cbh_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       o_in_stall,
    input  logic                       i_last_byte,
    input  logic                       i_empty_key,
    input  logic                       o_out_valid,
    input  logic                       i_out_stall,
    input  logic [cbh_pkg::BKT_W-1:0]  o_bucket_index,
    input  logic [cbh_pkg::CRC_W-1:0]  o_crc_value
);

    logic mid_req;
    logic end_req;

    assign mid_req = i_in_valid && !o_in_stall && !i_last_byte && !i_empty_key;
    assign end_req = i_in_valid && !o_in_stall && (i_last_byte || i_empty_key);

    // a held result keeps its value
    `CBH_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_bucket_index) && $stable(o_crc_value))

    // a middle byte never stalls the input
    `CBH_ASSERT_NEXT(a_mid_no_stall, mid_req, !o_in_stall)

    // a key end always occupies the remainder unit
    `CBH_ASSERT_NEXT(a_end_stalls, end_req, o_in_stall && !$rose(o_out_valid))

    // a result only appears at the end of a stalled key finish
    `CBH_ASSERT_NOW(a_out_after_busy, $rose(o_out_valid), $past(o_in_stall) && !o_in_stall)

endmodule

bind crc32c_string_bucket_hash_core cbh_checker u_cbh_checker (.*);
